>>> design/cea_pkg.sv
// ----------------------------------------------------------------------------
// cea_pkg: shared types and constants for the complex arithmetic core
// Holds the request and result payloads, operation codes and the record
// that travels down the divider cell chain.
// ----------------------------------------------------------------------------
package cea_pkg;

    localparam int DW = 32;          // data width, signed fixed point
    localparam int FB = 16;          // fraction bits
    localparam int MW = 2 * DW;      // product / divisor width
    localparam int QB = DW + 1;      // quotient bits resolved by the cell chain
    localparam int NW = MW + FB;     // scaled dividend width
    localparam int HW = NW - QB;     // dividend bits above the chain

    localparam logic [1:0] OP_MUL_REAL = 2'd0;
    localparam logic [1:0] OP_MUL_CPLX = 2'd1;
    localparam logic [1:0] OP_DIV_REAL = 2'd2;
    localparam logic [1:0] OP_DIV_CPLX = 2'd3;

    typedef struct packed {
        logic [1:0]           req_type;
        logic signed [DW-1:0] a_re;
        logic signed [DW-1:0] a_im;
        logic signed [DW-1:0] b_re;
        logic signed [DW-1:0] b_im;
    } cea_req_t;

    typedef struct packed {
        logic signed [DW-1:0] res_re;
        logic signed [DW-1:0] res_im;
        logic                 div_zero;
        logic                 overflow;
    } cea_res_t;

    typedef struct packed {
        logic [MW-1:0] rem_re;
        logic [MW-1:0] rem_im;
        logic [MW-1:0] den;
        logic [QB-1:0] num_re;
        logic [QB-1:0] num_im;
        logic [QB-1:0] quo_re;
        logic [QB-1:0] quo_im;
        logic          neg_re;
        logic          neg_im;
        logic          big_re;
        logic          big_im;
        logic          dz;
    } cea_div_t;

endpackage

>>> design/complex_elementwise_arith_core.sv
// ----------------------------------------------------------------------------
// complex_elementwise_arith_core: pipelined complex multiply / divide
// Element-wise complex arithmetic on signed Q16.16 values with saturation.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req) carries the op code and operands a, b.
//   res channel (res_valid/res_ready/res) returns one result per request,
//   in request order, with div_zero and overflow flags.
//   Every op goes through the same path: products, numerator and divisor
//   forming, scaling, then a chain of 33 division cells (one quotient bit
//   each), then the saturating output register. Multiplies divide by
//   2^(2*FB), which is the same as truncating the fraction bits.
//   One transfer per cycle is sustained while the receiver keeps res_ready
//   high; the cell chain sets the latency, not the rate.
//   Each stage holds its own valid bit, so a stalled receiver only freezes
//   full stages: empty stages keep filling until the chain backs up, and
//   req_ready drops only when every stage is occupied.
//   Reset clears all valid bits; the pipeline comes up empty and ready.
// ----------------------------------------------------------------------------
module complex_elementwise_arith_core
    import cea_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  cea_req_t req,
    output logic     res_valid,
    input  logic     res_ready,
    output cea_res_t res
);

    cea_div_t chain [0:QB];
    logic     chain_v [0:QB];
    logic     chain_r [0:QB];

    logic     out_v_reg;
    cea_res_t out_reg, out_next;
    logic     out_load;

    logic [QB-1:0] lim_re, lim_im;
    logic          sat_re, sat_im;
    logic [QB-1:0] m_re, m_im;

    // front stages: products, combine, scale
    cea_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req_valid),
        .in_ready  (req_ready),
        .in_data   (req),
        .out_valid (chain_v[0]),
        .out_ready (chain_r[0]),
        .out_data  (chain[0])
    );

    // division cell chain, one quotient bit per cell
    for (genvar i = 0; i < QB; i++)
    begin : g_cell
        cea_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_v[i]),
            .in_ready  (chain_r[i]),
            .in_data   (chain[i]),
            .out_valid (chain_v[i+1]),
            .out_ready (chain_r[i+1]),
            .out_data  (chain[i+1])
        );
    end

    // saturate each part against its sign's limit
    assign lim_re = chain[QB].neg_re ? QB'(1) << (DW - 1) : (QB'(1) << (DW - 1)) - QB'(1);
    assign lim_im = chain[QB].neg_im ? QB'(1) << (DW - 1) : (QB'(1) << (DW - 1)) - QB'(1);
    assign sat_re = chain[QB].big_re || (chain[QB].quo_re > lim_re);
    assign sat_im = chain[QB].big_im || (chain[QB].quo_im > lim_im);
    assign m_re   = sat_re ? lim_re : chain[QB].quo_re;
    assign m_im   = sat_im ? lim_im : chain[QB].quo_im;

    always_comb
    begin
        out_next          = '0;
        if (chain[QB].dz)
        begin
            out_next.div_zero = 1'b1;
        end
        else
        begin
            out_next.res_re   = chain[QB].neg_re ? DW'(-m_re) : DW'(m_re);
            out_next.res_im   = chain[QB].neg_im ? DW'(-m_im) : DW'(m_im);
            out_next.overflow = sat_re || sat_im;
        end
    end

    // output register: advance when empty or when the receiver takes it
    assign chain_r[QB] = !out_v_reg || res_ready;
    assign out_load    = chain_r[QB] && chain_v[QB];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (chain_r[QB])
        begin
            out_v_reg <= chain_v[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign res_valid = out_v_reg;
    assign res       = out_reg;

`ifndef SYNTHESIS
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.div_zero |-> res.res_re == '0 && res.res_im == '0 && !res.overflow)
        else $error("divide-by-zero result not cleared");

    a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.overflow |->
            res.res_re == {1'b0, {(DW-1){1'b1}}} || res.res_re == {1'b1, {(DW-1){1'b0}}} ||
            res.res_im == {1'b0, {(DW-1){1'b1}}} || res.res_im == {1'b1, {(DW-1){1'b0}}})
        else $error("overflow flagged without a saturated part");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> req_ready)
        else $error("request stalled while output register is empty");
`endif

endmodule

>>> design/cea_front.sv
// ----------------------------------------------------------------------------
// cea_front: product, combine and divider setup stages
// Three pipeline stages: partial products, numerator/divisor forming,
// and magnitude scaling with the early overflow check.
// ----------------------------------------------------------------------------
module cea_front
    import cea_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  cea_req_t in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output cea_div_t out_data
);

    logic s1_v_reg, s2_v_reg, s3_v_reg;
    logic s1_ready, s2_ready, s3_ready;

    // stage 1 payload
    logic signed [MW-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, p_bb_reg, p_cc_reg;
    logic signed [DW-1:0] a_re_reg, a_im_reg, b_re_reg;
    logic [1:0]           op_reg;
    logic                 bre_zero_reg, b_zero_reg;

    // stage 2 payload
    logic signed [MW:0]   n_re_reg, n_im_reg;
    logic [MW-1:0]        den_reg;
    logic                 dz2_reg;

    logic signed [MW:0]   n_re_next, n_im_next;
    logic [MW-1:0]        den_next, bre_mag;
    logic signed [MW-1:0] bre_ext;
    logic                 dz2_next;

    // stage 3
    cea_div_t             d3_reg, d3_next;
    logic [MW-1:0]        mag_re, mag_im;
    logic [NW-1:0]        sc_re, sc_im;

    assign s3_ready = !s3_v_reg || out_ready;
    assign s2_ready = !s2_v_reg || s3_ready;
    assign s1_ready = !s1_v_reg || s2_ready;
    assign in_ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready) s1_v_reg <= in_valid;
            if (s2_ready) s2_v_reg <= s1_v_reg;
            if (s3_ready) s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            p_rr_reg     <= in_data.a_re * in_data.b_re;
            p_ii_reg     <= in_data.a_im * in_data.b_im;
            p_ri_reg     <= in_data.a_re * in_data.b_im;
            p_ir_reg     <= in_data.a_im * in_data.b_re;
            p_bb_reg     <= in_data.b_re * in_data.b_re;
            p_cc_reg     <= in_data.b_im * in_data.b_im;
            a_re_reg     <= in_data.a_re;
            a_im_reg     <= in_data.a_im;
            b_re_reg     <= in_data.b_re;
            op_reg       <= in_data.req_type;
            bre_zero_reg <= (in_data.b_re == '0);
            b_zero_reg   <= (in_data.b_re == '0) && (in_data.b_im == '0);
        end
    end

    assign bre_ext = MW'(b_re_reg);
    assign bre_mag = bre_ext[MW-1] ? MW'(-bre_ext) : MW'(bre_ext);

    always_comb
    begin
        n_re_next = (MW+1)'(p_rr_reg);
        n_im_next = (MW+1)'(p_ir_reg);
        den_next  = MW'(1) << (2 * FB);
        dz2_next  = 1'b0;
        case (op_reg)
            OP_MUL_REAL:
            begin
                n_re_next = (MW+1)'(p_rr_reg);
                n_im_next = (MW+1)'(p_ir_reg);
            end
            OP_MUL_CPLX:
            begin
                n_re_next = (MW+1)'(p_rr_reg) - (MW+1)'(p_ii_reg);
                n_im_next = (MW+1)'(p_ri_reg) + (MW+1)'(p_ir_reg);
            end
            OP_DIV_REAL:
            begin
                // fold the divisor sign into the numerator
                n_re_next = b_re_reg[DW-1] ? -(MW+1)'(a_re_reg) : (MW+1)'(a_re_reg);
                n_im_next = b_re_reg[DW-1] ? -(MW+1)'(a_im_reg) : (MW+1)'(a_im_reg);
                den_next  = bre_mag;
                dz2_next  = bre_zero_reg;
            end
            OP_DIV_CPLX:
            begin
                n_re_next = (MW+1)'(p_rr_reg) + (MW+1)'(p_ii_reg);
                n_im_next = (MW+1)'(p_ir_reg) - (MW+1)'(p_ri_reg);
                den_next  = MW'($unsigned(p_bb_reg)) + MW'($unsigned(p_cc_reg));
                dz2_next  = b_zero_reg;
            end
            default:
            begin
                dz2_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_v_reg)
        begin
            n_re_reg <= n_re_next;
            n_im_reg <= n_im_next;
            den_reg  <= den_next;
            dz2_reg  <= dz2_next;
        end
    end

    // magnitude, scale by the fraction bits, check the quotient top
    assign mag_re = n_re_reg[MW] ? MW'(-n_re_reg) : MW'(n_re_reg);
    assign mag_im = n_im_reg[MW] ? MW'(-n_im_reg) : MW'(n_im_reg);
    assign sc_re  = {mag_re, {FB{1'b0}}};
    assign sc_im  = {mag_im, {FB{1'b0}}};

    always_comb
    begin
        d3_next        = '0;
        d3_next.den    = den_reg;
        d3_next.rem_re = MW'(sc_re[NW-1:QB]);
        d3_next.rem_im = MW'(sc_im[NW-1:QB]);
        d3_next.num_re = sc_re[QB-1:0];
        d3_next.num_im = sc_im[QB-1:0];
        d3_next.neg_re = n_re_reg[MW];
        d3_next.neg_im = n_im_reg[MW];
        d3_next.big_re = MW'(sc_re[NW-1:QB]) >= den_reg;
        d3_next.big_im = MW'(sc_im[NW-1:QB]) >= den_reg;
        d3_next.dz     = dz2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && s2_v_reg)
        begin
            d3_reg <= d3_next;
        end
    end

    assign out_valid = s3_v_reg;
    assign out_data  = d3_reg;

endmodule

>>> design/cea_cell.sv
// ----------------------------------------------------------------------------
// cea_cell: one restoring division step
// Resolves one quotient bit for both result parts and hands the record on.
// ----------------------------------------------------------------------------
module cea_cell
    import cea_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  cea_div_t in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output cea_div_t out_data
);

    logic          v_reg;
    cea_div_t      d_reg, d_next;
    logic [MW-1:0] try_re, try_im;
    logic          hit_re, hit_im;

    assign in_ready = !v_reg || out_ready;

    // remainder stays below the divisor, so its top bit is always clear
    assign try_re = {in_data.rem_re[MW-2:0], in_data.num_re[QB-1]};
    assign try_im = {in_data.rem_im[MW-2:0], in_data.num_im[QB-1]};
    assign hit_re = try_re >= in_data.den;
    assign hit_im = try_im >= in_data.den;

    always_comb
    begin
        d_next        = in_data;
        d_next.rem_re = hit_re ? try_re - in_data.den : try_re;
        d_next.rem_im = hit_im ? try_im - in_data.den : try_im;
        d_next.num_re = {in_data.num_re[QB-2:0], 1'b0};
        d_next.num_im = {in_data.num_im[QB-2:0], 1'b0};
        d_next.quo_re = {in_data.quo_re[QB-2:0], hit_re};
        d_next.quo_im = {in_data.quo_im[QB-2:0], hit_im};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            d_reg <= d_next;
        end
    end

    assign out_valid = v_reg;
    assign out_data  = d_reg;

endmodule
